// File: hdl/fvn_pkg.sv
// Shared types and constants for the fractal value noise block.
package fvn_pkg;

    // fraction bits of every fixed-point quantity
    localparam int FRAC_BITS = 16;

    localparam logic [1:0] MODE_FBM    = 2'd0;
    localparam logic [1:0] MODE_BILLOW = 2'd1;
    localparam logic [1:0] MODE_RIDGED = 2'd2;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_SEED    = 3'd1;
    localparam logic [2:0] REG_OCTAVES = 3'd2;
    localparam logic [2:0] REG_LACUN   = 3'd3;
    localparam logic [2:0] REG_PERSIST = 3'd4;

    localparam logic [31:0] SEED_STEP  = 32'd1000;
    localparam logic [31:0] HASH_MUL_Z = 32'd57;
    localparam logic [31:0] HASH_MUL_S = 32'd131;
    localparam logic [31:0] HASH_C1    = 32'd15731;
    localparam logic [31:0] HASH_C2    = 32'd789221;
    localparam logic [31:0] HASH_C3    = 32'd1376312589;

    // hash unit operation
    typedef struct packed {
        logic        start;
        logic [31:0] cx;
        logic [31:0] cz;
        logic [31:0] seed;
    } fvn_hash_req_t;

endpackage

// File: hdl/fvn_hash.sv
// Multicycle lattice hash: one 32x32 multiply per cycle.
module fvn_hash (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fvn_pkg::fvn_hash_req_t req,
    output logic                  done,
    output logic [30:0]           hash
);

    localparam logic [2:0] H_IDLE = 3'd0;
    localparam logic [2:0] H_SQ   = 3'd1;
    localparam logic [2:0] H_M1   = 3'd2;
    localparam logic [2:0] H_M2   = 3'd3;
    localparam logic [2:0] H_OUT  = 3'd4;

    logic [2:0]  st_reg, st_next;
    logic [31:0] n_reg, n_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] n0;

    assign n0   = req.cx + req.cz * fvn_pkg::HASH_MUL_Z + req.seed * fvn_pkg::HASH_MUL_S;
    assign prod = mul_a * mul_b;

    always_comb
    begin
        st_next  = st_reg;
        n_next   = n_reg;
        acc_next = acc_reg;
        mul_a    = n_reg;
        mul_b    = n_reg;
        unique case (st_reg)
            H_IDLE:
            begin
                if (req.start)
                begin
                    n_next  = (n0 << 13) ^ n0;
                    st_next = H_SQ;
                end
            end
            H_SQ:
            begin
                acc_next = prod;
                st_next  = H_M1;
            end
            H_M1:
            begin
                mul_a    = acc_reg;
                mul_b    = fvn_pkg::HASH_C1;
                acc_next = prod + fvn_pkg::HASH_C2;
                st_next  = H_M2;
            end
            H_M2:
            begin
                mul_b    = acc_reg;
                acc_next = prod + fvn_pkg::HASH_C3;
                st_next  = H_OUT;
            end
            H_OUT:   st_next = H_IDLE;
            default: st_next = H_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= H_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        acc_reg <= acc_next;
    end

    assign done = (st_reg == H_OUT);
    assign hash = acc_reg[30:0];

endmodule

// File: hdl/fractal_value_noise_2d_top.sv
// Top level of the fractal 2-D value noise generator.
//
// Channel   Dir  Transfer                   Payload
// s_axis    in   s_axis_tvalid&tready       tdata[31:0] x_coord, [63:32] z_coord
// m_axis    out  m_axis_tvalid&tready       tdata[23:0] noise_value
// cfg       in   cfg_we                     cfg_index selects register
//
// Each octave runs two scaling steps, the shared hash unit (four corners in
// turn), four smoothstep steps, three lerps, two ridge steps in ridged mode
// only and three accumulate/update steps; all but the hash unit use one shared
// 33x33 multiply. An item adds an accept step before and a finish step after.
// s_axis_tready is high only when idle; a finished result waits in the finish
// state while the output register is still full and not being drained.
// Reset clears control state and the configuration registers to their defaults.
module fractal_value_noise_2d_top #(
    parameter int MAX_OCTAVES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // x_coord, z_coord
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // noise_value
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int FRAC_BITS = fvn_pkg::FRAC_BITS;
    localparam int CW = $clog2(MAX_OCTAVES + 1);
    localparam logic signed [47:0] ONE = 48'sd1 <<< FRAC_BITS;
    localparam logic [23:0] FREQ_MAX = 24'hFFFFFF;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SX    = 5'd1;
    localparam logic [4:0] S_SZ    = 5'd2;
    localparam logic [4:0] S_H     = 5'd3;
    localparam logic [4:0] S_HW    = 5'd4;
    localparam logic [4:0] S_T2X   = 5'd5;
    localparam logic [4:0] S_SMX   = 5'd6;
    localparam logic [4:0] S_T2Z   = 5'd7;
    localparam logic [4:0] S_SMZ   = 5'd8;
    localparam logic [4:0] S_LA    = 5'd9;
    localparam logic [4:0] S_LB    = 5'd10;
    localparam logic [4:0] S_LC    = 5'd11;
    localparam logic [4:0] S_R1    = 5'd12;
    localparam logic [4:0] S_R2    = 5'd13;
    localparam logic [4:0] S_ACC   = 5'd14;
    localparam logic [4:0] S_AMP   = 5'd15;
    localparam logic [4:0] S_FRQ   = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    // configuration
    logic [1:0]  mode_reg;
    logic [31:0] seed_reg;
    logic [4:0]  oct_reg;
    logic [23:0] lac_reg;
    logic [16:0] pers_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= fvn_pkg::MODE_FBM;
            seed_reg <= '0;
            oct_reg  <= 5'd4;
            lac_reg  <= 24'd131072;
            pers_reg <= 17'd32768;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fvn_pkg::REG_MODE:    mode_reg <= cfg_data[1:0];
                fvn_pkg::REG_SEED:    seed_reg <= cfg_data;
                fvn_pkg::REG_OCTAVES: oct_reg  <= cfg_data[4:0];
                fvn_pkg::REG_LACUN:   lac_reg  <= cfg_data[23:0];
                fvn_pkg::REG_PERSIST: pers_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    logic [4:0]  st_reg, st_next;
    logic [CW-1:0] oct_cnt_reg, oct_cnt_next, oct_lim_reg, oct_lim_next;
    logic [1:0]  corner_reg, corner_next;
    logic signed [31:0] x_reg, x_next, z_reg, z_next;
    logic [23:0] freq_reg, freq_next;
    logic [16:0] amp_reg, amp_next;
    logic signed [47:0] weight_reg, weight_next;
    logic signed [47:0] sum_reg, sum_next;
    logic [31:0] oseed_reg, oseed_next;
    logic signed [47:0] sx_reg, sx_next, sz_reg, sz_next;
    logic signed [47:0] v_reg [4];
    logic signed [47:0] v_next [4];
    logic signed [47:0] wx_reg, wx_next, wz_reg, wz_next;
    logic signed [47:0] t_reg, t_next;     // scratch
    logic signed [47:0] a_reg, a_next;
    logic signed [47:0] b_reg, b_next;
    logic [23:0] out_reg, out_next;
    logic        ov_reg, ov_next;
    logic [1:0]  cmode_reg, cmode_next;
    logic [16:0] cpers_reg, cpers_next;

    // shared multiplier, 33x33 signed; every operand fits in 33 bits
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [65:0] mul_sh;
    assign mul_p  = mul_a * mul_b;
    assign mul_sh = mul_p >>> FRAC_BITS;

    fvn_pkg::fvn_hash_req_t hreq;
    logic        hdone;
    logic [30:0] hval;
    logic [31:0] cxs, czs;

    fvn_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .done  (hdone),
        .hash  (hval)
    );

    assign cxs = sx_reg[FRAC_BITS +: 32] + {31'd0, corner_reg[0]};
    assign czs = sz_reg[FRAC_BITS +: 32] + {31'd0, corner_reg[1]};

    logic signed [47:0] an, nval, term;
    logic signed [47:0] fx, fz;
    assign fx = {{(48-FRAC_BITS){1'b0}}, sx_reg[FRAC_BITS-1:0]};
    assign fz = {{(48-FRAC_BITS){1'b0}}, sz_reg[FRAC_BITS-1:0]};
    assign nval = a_reg;
    assign an   = nval[47] ? -nval : nval;

    always_comb
    begin
        st_next      = st_reg;
        oct_cnt_next = oct_cnt_reg;
        oct_lim_next = oct_lim_reg;
        corner_next  = corner_reg;
        x_next = x_reg;  z_next = z_reg;
        freq_next = freq_reg; amp_next = amp_reg; weight_next = weight_reg;
        sum_next = sum_reg; oseed_next = oseed_reg;
        sx_next = sx_reg; sz_next = sz_reg;
        v_next = v_reg;
        wx_next = wx_reg; wz_next = wz_reg;
        t_next = t_reg; a_next = a_reg; b_next = b_reg;
        out_next = out_reg; ov_next = ov_reg;
        cmode_next = cmode_reg; cpers_next = cpers_reg;
        mul_a = '0; mul_b = '0; term = '0;
        hreq.start = 1'b0;
        hreq.cx    = cxs;
        hreq.cz    = czs;
        hreq.seed  = oseed_reg;
        if (ov_reg && m_axis_tready)
            ov_next = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    x_next = s_axis_tdata[31:0];
                    z_next = s_axis_tdata[63:32];
                    freq_next = 24'(ONE);
                    amp_next  = 17'(ONE);
                    weight_next = ONE;
                    sum_next = '0;
                    oseed_next = seed_reg;
                    oct_cnt_next = '0;
                    oct_lim_next = (int'(oct_reg) > MAX_OCTAVES) ? CW'(MAX_OCTAVES)
                                                                 : CW'(oct_reg);
                    cmode_next = mode_reg;
                    cpers_next = (pers_reg > 17'(ONE)) ? 17'(ONE) : pers_reg;
                    st_next = (oct_reg == 5'd0) ? S_DONE : S_SX;
                end
            end
            S_SX:
            begin
                mul_a = 33'(x_reg); mul_b = {9'd0, freq_reg};
                sx_next = mul_sh[47:0]; st_next = S_SZ;
            end
            S_SZ:
            begin
                mul_a = 33'(z_reg); mul_b = {9'd0, freq_reg};
                sz_next = mul_sh[47:0]; corner_next = 2'd0; st_next = S_H;
            end
            S_H:
            begin
                hreq.start = 1'b1; st_next = S_HW;
            end
            S_HW:
            begin
                if (hdone)
                begin
                    v_next[corner_reg] = ONE - 48'(hval >> (30 - FRAC_BITS));
                    corner_next = corner_reg + 2'd1;
                    st_next = (corner_reg == 2'd3) ? S_T2X : S_H;
                end
            end
            S_T2X:
            begin
                mul_a = 33'(fx); mul_b = 33'(fx);
                t_next = mul_sh[47:0]; st_next = S_SMX;
            end
            S_SMX:
            begin
                mul_a = 33'(t_reg); mul_b = 33'(3 * ONE - 2 * fx);
                wx_next = mul_sh[47:0]; st_next = S_T2Z;
            end
            S_T2Z:
            begin
                mul_a = 33'(fz); mul_b = 33'(fz);
                t_next = mul_sh[47:0]; st_next = S_SMZ;
            end
            S_SMZ:
            begin
                mul_a = 33'(t_reg); mul_b = 33'(3 * ONE - 2 * fz);
                wz_next = mul_sh[47:0]; st_next = S_LA;
            end
            S_LA:
            begin
                mul_a = 33'(v_reg[1] - v_reg[0]); mul_b = 33'(wx_reg);
                a_next = v_reg[0] + mul_sh[47:0]; st_next = S_LB;
            end
            S_LB:
            begin
                mul_a = 33'(v_reg[3] - v_reg[2]); mul_b = 33'(wx_reg);
                b_next = v_reg[2] + mul_sh[47:0]; st_next = S_LC;
            end
            S_LC:
            begin
                mul_a = 33'(b_reg - a_reg); mul_b = 33'(wz_reg);
                a_next = a_reg + mul_sh[47:0];
                st_next = (cmode_reg == fvn_pkg::MODE_RIDGED) ? S_R1 : S_ACC;
            end
            S_R1:
            begin
                mul_a = 33'((an > ONE) ? '0 : ONE - an);
                mul_b = 33'((an > ONE) ? '0 : ONE - an);
                t_next = mul_sh[47:0]; st_next = S_R2;
            end
            S_R2:
            begin
                mul_a = 33'(t_reg); mul_b = 33'(weight_reg);
                t_next = mul_sh[47:0];
                weight_next = ((mul_sh[47:0] <<< 1) > ONE) ? ONE : (mul_sh[47:0] <<< 1);
                st_next = S_ACC;
            end
            S_ACC:
            begin
                case (cmode_reg)
                    fvn_pkg::MODE_BILLOW: term = (an <<< 1) - ONE;
                    fvn_pkg::MODE_RIDGED: term = t_reg;
                    default:              term = nval;
                endcase
                mul_a = 33'(term); mul_b = {16'd0, amp_reg};
                sum_next = sum_reg + mul_sh[47:0]; st_next = S_AMP;
            end
            S_AMP:
            begin
                mul_a = {16'd0, amp_reg}; mul_b = {16'd0, cpers_reg};
                amp_next = mul_sh[16:0]; st_next = S_FRQ;
            end
            S_FRQ:
            begin
                mul_a = {9'd0, freq_reg}; mul_b = {9'd0, lac_reg};
                freq_next = (mul_sh > 66'(FREQ_MAX)) ? FREQ_MAX : mul_sh[23:0];
                oseed_next = oseed_reg + fvn_pkg::SEED_STEP;
                oct_cnt_next = oct_cnt_reg + 1'b1;
                st_next = (oct_cnt_reg + 1'b1 == oct_lim_reg) ? S_DONE : S_SX;
            end
            S_DONE:
            begin
                if (!ov_next)
                begin
                    out_next = (sum_reg > 48'sd8388607) ? 24'h7FFFFF :
                               (sum_reg < -48'sd8388608) ? 24'h800000 : sum_reg[23:0];
                    ov_next = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oct_cnt_reg <= oct_cnt_next; oct_lim_reg <= oct_lim_next;
        corner_reg <= corner_next; x_reg <= x_next; z_reg <= z_next;
        freq_reg <= freq_next; amp_reg <= amp_next; weight_reg <= weight_next;
        sum_reg <= sum_next; oseed_reg <= oseed_next;
        sx_reg <= sx_next; sz_reg <= sz_next; v_reg <= v_next;
        wx_reg <= wx_next; wz_reg <= wz_next; t_reg <= t_next;
        a_reg <= a_next; b_reg <= b_next; out_reg <= out_next;
        cmode_reg <= cmode_next; cpers_reg <= cpers_next;
    end

    assign s_axis_tready = (st_reg == S_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

    // a new result only appears when the sequencer finishes
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(st_reg) == S_DONE)
        else $error("result without finish");
    // the output holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result lost");
    // no new item while busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != S_IDLE |-> !s_axis_tready)
        else $error("ready while busy");

endmodule
